// ----- sv/bb3_pkg.sv -----
`timescale 1ns / 1ps

package bb3_pkg;

   // Width of a coordinate on the result channel
   localparam int CoordW = 10;

   // Width of a configuration register
   localparam int CsrW = 11;

   // Reciprocal scaling for the rounded division
   localparam int RecipShift = 18;
   localparam int RecipW = 18;

   // Configuration register indexes
   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Incoming pixel word, also the storage format of line stores and window
   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [7:0]        out_red;
      logic [7:0]        out_green;
      logic [7:0]        out_blue;
      logic [CoordW-1:0] out_row;
      logic [CoordW-1:0] out_column;
      logic              run_last;
   } rsp_word_type;

   // Position of a pixel and the edge flags the result sequencer needs
   typedef struct packed {
      logic [CoordW-1:0] row;
      logic [CoordW-1:0] col;
      logic [CoordW-1:0] col_last;
      logic              row_ge1;
      logic              row_ge2;
      logic              col_ge1;
      logic              col_ge2;
      logic              row_end;
      logic              last_row;
   } item_type;

endpackage

// ----- sv/box_blur_3x3_clipped_edges.sv -----
`timescale 1ns / 1ps

// 3x3 box blur of an RGB frame, edges clipped (divisor 9, 6, 4 or fewer).
// req_*: pixel words in raster order, valid/ready. rsp_*: blurred pixels
// with their row and column, valid/ready; run_last marks the final result
// caused by an input word. A word causes up to four results, on the row
// above (one pixel behind) and, on the last row, on its own row.
// csr_*: write-only registers, index 0 image width, 1 image height; write
// them only while the block is idle.
// A word passes the read stage and the result sequencer; each result then
// passes the sum stage and the output register. A word holds the sequencer
// until its k results have been issued, so one pixel per cycle inside a
// frame while rsp_ready is high, and less on row ends and the last row.
// The sequencer builds one result a cycle unless rsp stalls.
// When rsp_ready is low the pipe fills (two result words and two pixel
// words) and then req_ready drops; nothing is lost. Reset empties the pipe,
// clears the row and column counts and the window and sets both dimensions
// to MAX_WIDTH and MAX_HEIGHT, each capped at 1024; the line stores are not
// cleared, as samples outside the frame are never used.
module box_blur_3x3_clipped_edges #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  bb3_pkg::req_word_type      req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bb3_pkg::rsp_word_type      rsp_data,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [bb3_pkg::CsrW-1:0]   csr_wdata
);

   localparam int ColW = $clog2(MAX_WIDTH);
   localparam int RowW = $clog2(MAX_HEIGHT);
   localparam logic [bb3_pkg::CsrW-1:0] WidthLastReset =
      bb3_pkg::CsrW'(((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1);
   localparam logic [bb3_pkg::CsrW-1:0] HeightLastReset =
      bb3_pkg::CsrW'(((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024) - 1);

   // clamp a dimension to 1..maxv and return its last index
   function automatic logic [bb3_pkg::CsrW-1:0] last_index(
      input logic [bb3_pkg::CsrW-1:0] v,
      input int                       maxv
   );
      logic [bb3_pkg::CsrW-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (32'(v) > 32'(maxv)) begin
         r = bb3_pkg::CsrW'(maxv - 1);
      end else begin
         r = v - 1'b1;
      end
      return r;
   endfunction

   logic [bb3_pkg::CsrW-1:0] w_last_ff;
   logic [bb3_pkg::CsrW-1:0] h_last_ff;
   logic [ColW-1:0]          col_ff;
   logic [ColW-1:0]          col_in;
   logic [RowW-1:0]          row_ff;
   logic [RowW-1:0]          row_in;

   logic                              take;
   logic                              row_end;
   logic                              last_row;
   logic [ColW-1:0]                   rd_addr;
   bb3_pkg::item_type                 item;
   logic                              item_valid;
   logic                              item_ready;
   bb3_pkg::item_type                 item_s1;
   bb3_pkg::req_word_type [2:0][2:0]  window;

   assign take     = req_valid & req_ready;
   assign req_ready = ~item_valid | item_ready;

   // position of the incoming word
   assign row_end  = 32'(col_ff) >= 32'(w_last_ff);
   assign last_row = 32'(row_ff) >= 32'(h_last_ff);
   assign rd_addr  = (32'(col_ff) < 32'(MAX_WIDTH)) ? col_ff : '0;

   always_comb begin
      item.row      = bb3_pkg::CoordW'(row_ff);
      item.col      = bb3_pkg::CoordW'(col_ff);
      item.col_last = bb3_pkg::CoordW'(w_last_ff);
      item.row_ge1  = (row_ff != '0);
      item.row_ge2  = (32'(row_ff) >= 32'd2);
      item.col_ge1  = (col_ff != '0);
      item.col_ge2  = (32'(col_ff) >= 32'd2);
      item.row_end  = row_end;
      item.last_row = last_row;
   end

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : (row_ff + 1'b1);
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= WidthLastReset;
         h_last_ff <= HeightLastReset;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               bb3_pkg::CSR_IMAGE_WIDTH:  w_last_ff <= last_index(csr_wdata, MAX_WIDTH);
               bb3_pkg::CSR_IMAGE_HEIGHT: h_last_ff <= last_index(csr_wdata, MAX_HEIGHT);
            endcase
         end
      end
   end

   bb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rd_addr    (rd_addr),
      .pixel      (req_data),
      .item       (item),
      .item_ready (item_ready),
      .item_valid (item_valid),
      .item_out   (item_s1),
      .window     (window)
   );

   bb3_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item_s1),
      .window     (window),
      .item_ready (item_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // an accepted word sits in the read stage on the next cycle
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> item_valid)
      else $error("accepted word missing from read stage");

   // a word held by the sequencer keeps its position flags
   a_item_holds: assert property (@(posedge clock) disable iff (reset)
      item_valid && !item_ready |=> item_valid && $stable(item_s1))
      else $error("read stage changed while stalled");

   // a row end sends the column count back to zero
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      take && row_end |=> col_ff == '0)
      else $error("column count did not wrap at row end");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !item_valid)
      else $error("pipe not empty after reset");
`endif

endmodule

// ----- sv/bb3_ram.sv -----
`timescale 1ns / 1ps

module bb3_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // single write port, registered read (old data on a same-address collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bb3_window.sv -----
`timescale 1ns / 1ps

module bb3_window #(
   parameter int MAX_WIDTH = 1024,
   localparam int AddrW = $clog2(MAX_WIDTH)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic [AddrW-1:0]                      rd_addr,
   input  bb3_pkg::req_word_type                 pixel,
   input  bb3_pkg::item_type                     item,
   input  logic                                  item_ready,
   output logic                                  item_valid,
   output bb3_pkg::item_type                     item_out,
   output bb3_pkg::req_word_type [2:0][2:0]      window
);

   localparam int PixW = $bits(bb3_pkg::req_word_type);

   logic                  s1_valid_ff;
   bb3_pkg::req_word_type s1_pixel_ff;
   bb3_pkg::item_type     s1_item_ff;
   logic [AddrW-1:0]      s1_addr_ff;
   logic                  s1_fwd_ff;
   bb3_pkg::req_word_type fwd_older_ff;
   bb3_pkg::req_word_type fwd_newer_ff;

   bb3_pkg::req_word_type [2:0][2:0] win_ff;
   bb3_pkg::req_word_type [2:0][2:0] win_in;

   logic [PixW-1:0]       older_rd;
   logic [PixW-1:0]       newer_rd;
   bb3_pkg::req_word_type older_val;
   bb3_pkg::req_word_type newer_val;
   logic                  adv;
   logic                  fwd_hit;

   // line stores: older holds row r-2, newer row r-1
   bb3_ram #(.Width(PixW), .Depth(MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (adv),
      .wr_addr (s1_addr_ff),
      .wr_data (newer_val),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (older_rd)
   );

   bb3_ram #(.Width(PixW), .Depth(MAX_WIDTH)) u_newer (
      .clock   (clock),
      .wr_en   (adv),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (newer_rd)
   );

   assign adv = s1_valid_ff & item_ready;

   // forward the pending write-back when the next word reads the same column
   assign fwd_hit   = adv & (s1_addr_ff == rd_addr);
   assign older_val = s1_fwd_ff ? fwd_older_ff : bb3_pkg::req_word_type'(older_rd);
   assign newer_val = s1_fwd_ff ? fwd_newer_ff : bb3_pkg::req_word_type'(newer_rd);

   // window shifts one column on each word handed on
   always_comb begin
      win_in = win_ff;
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            win_in[a][0] = win_ff[a][1];
            win_in[a][1] = win_ff[a][2];
         end
         win_in[0][2] = older_val;
         win_in[1][2] = newer_val;
         win_in[2][2] = s1_pixel_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
         win_ff      <= '0;
      end else begin
         if (take) begin
            s1_valid_ff <= 1'b1;
            s1_fwd_ff   <= fwd_hit;
         end else if (adv) begin
            s1_valid_ff <= 1'b0;
         end
         win_ff <= win_in;
      end
   end

   // payload of the read stage
   always_ff @(posedge clock) begin
      if (take) begin
         s1_pixel_ff  <= pixel;
         s1_item_ff   <= item;
         s1_addr_ff   <= rd_addr;
         fwd_older_ff <= newer_val;
         fwd_newer_ff <= s1_pixel_ff;
      end
   end

   assign item_valid = s1_valid_ff;
   assign item_out   = s1_item_ff;
   assign window     = win_ff;

endmodule

// ----- sv/bb3_emit.sv -----
`timescale 1ns / 1ps

module bb3_emit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   input  bb3_pkg::item_type                item,
   input  bb3_pkg::req_word_type [2:0][2:0] window,
   output logic                             item_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bb3_pkg::rsp_word_type            rsp_data
);

   localparam int SumW = 12;
   localparam int NumW = 13;
   localparam int ProdW = NumW + bb3_pkg::RecipW;

   // reciprocal of 2n, scaled by 2^RecipShift and rounded up
   function automatic logic [bb3_pkg::RecipW-1:0] recip(input logic [3:0] n);
      logic [bb3_pkg::RecipW-1:0] m;
      case (n)
         4'd1:    m = 18'd131072;
         4'd2:    m = 18'd65536;
         4'd3:    m = 18'd43691;
         4'd4:    m = 18'd32768;
         4'd6:    m = 18'd21846;
         4'd9:    m = 18'd14564;
         default: m = '0;
      endcase
      return m;
   endfunction

   // sequencer: pending results of the word in hand
   logic [3:0]        pend_ff;
   logic [3:0]        pend_in;
   bb3_pkg::item_type item_ff;
   logic [3:0]        sel;
   logic [3:0]        rest;
   logic [3:0]        new_mask;
   logic              issue;
   logic              take;

   // sum stage
   logic                    s3_valid_ff;
   logic [SumW-1:0]         s3_sum_red_ff;
   logic [SumW-1:0]         s3_sum_green_ff;
   logic [SumW-1:0]         s3_sum_blue_ff;
   logic [3:0]              s3_n_ff;
   logic [bb3_pkg::CoordW-1:0] s3_row_ff;
   logic [bb3_pkg::CoordW-1:0] s3_col_ff;
   logic                    s3_last_ff;
   logic                    s3_free;
   logic                    s3_adv;

   // output stage
   logic                  rsp_valid_ff;
   bb3_pkg::rsp_word_type rsp_data_ff;

   logic                       upper;
   logic                       at_end;
   logic [1:0]                 rlo;
   logic [1:0]                 clo;
   logic [1:0]                 nr;
   logic [1:0]                 nc;
   logic [3:0]                 n;
   logic [SumW-1:0]            sum_red;
   logic [SumW-1:0]            sum_green;
   logic [SumW-1:0]            sum_blue;
   logic [bb3_pkg::CoordW-1:0] row_out;
   logic [bb3_pkg::CoordW-1:0] col_out;

   logic [bb3_pkg::RecipW-1:0] m;
   logic [ProdW-1:0]           prod_red;
   logic [ProdW-1:0]           prod_green;
   logic [ProdW-1:0]           prod_blue;

   // handshakes along the pipe
   assign s3_adv  = ~rsp_valid_ff | rsp_ready;
   assign s3_free = ~s3_valid_ff | s3_adv;
   assign sel     = pend_ff & (~pend_ff + 4'd1);
   assign rest    = pend_ff & ~sel;
   assign issue   = (pend_ff != '0) & s3_free;
   assign item_ready = (pend_ff == '0) | (issue & (rest == '0));
   assign take    = item_valid & item_ready;

   // results of a word, in output order
   assign new_mask = {item.last_row & item.row_end,
                      item.last_row & item.col_ge1,
                      item.row_ge1  & item.row_end,
                      item.row_ge1  & item.col_ge1};

   always_comb begin
      pend_in = pend_ff;
      if (take) begin
         pend_in = new_mask;
      end else if (issue) begin
         pend_in = rest;
      end
   end

   // neighbourhood bounds of the selected result
   always_comb begin
      upper  = sel[0] | sel[1];
      at_end = sel[1] | sel[3];
      if (upper) begin
         rlo = item_ff.row_ge2 ? 2'd0 : 2'd1;
      end else begin
         rlo = item_ff.row_ge1 ? 2'd1 : 2'd2;
      end
      if (at_end) begin
         clo = item_ff.col_ge1 ? 2'd1 : 2'd2;
      end else begin
         clo = item_ff.col_ge2 ? 2'd0 : 2'd1;
      end
      nr = 2'd3 - rlo;
      nc = 2'd3 - clo;
      n  = 4'(nr) * 4'(nc);
      row_out = upper  ? (item_ff.row - 10'd1) : item_ff.row;
      col_out = at_end ? item_ff.col_last      : (item_ff.col - 10'd1);
   end

   // add up the cells inside the frame
   always_comb begin
      sum_red   = '0;
      sum_green = '0;
      sum_blue  = '0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            if ((a >= int'(rlo)) && (b >= int'(clo))) begin
               sum_red   = sum_red   + SumW'(window[a][b].in_red);
               sum_green = sum_green + SumW'(window[a][b].in_green);
               sum_blue  = sum_blue  + SumW'(window[a][b].in_blue);
            end
         end
      end
   end

   // rounded mean: (2*sum + n) / (2n) by reciprocal multiplication
   always_comb begin
      m = recip(s3_n_ff);
      prod_red   = ProdW'({s3_sum_red_ff, 1'b0} + NumW'(s3_n_ff)) * ProdW'(m);
      prod_green = ProdW'({s3_sum_green_ff, 1'b0} + NumW'(s3_n_ff)) * ProdW'(m);
      prod_blue  = ProdW'({s3_sum_blue_ff, 1'b0} + NumW'(s3_n_ff)) * ProdW'(m);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (issue) begin
            s3_valid_ff <= 1'b1;
         end else if (s3_adv) begin
            s3_valid_ff <= 1'b0;
         end
         if (s3_valid_ff & s3_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item;
      end
      if (issue) begin
         s3_sum_red_ff   <= sum_red;
         s3_sum_green_ff <= sum_green;
         s3_sum_blue_ff  <= sum_blue;
         s3_n_ff         <= n;
         s3_row_ff       <= row_out;
         s3_col_ff       <= col_out;
         s3_last_ff      <= (rest == '0);
      end
      if (s3_valid_ff & s3_adv) begin
         rsp_data_ff.out_red    <= prod_red[bb3_pkg::RecipShift +: 8];
         rsp_data_ff.out_green  <= prod_green[bb3_pkg::RecipShift +: 8];
         rsp_data_ff.out_blue   <= prod_blue[bb3_pkg::RecipShift +: 8];
         rsp_data_ff.out_row    <= s3_row_ff;
         rsp_data_ff.out_column <= s3_col_ff;
         rsp_data_ff.run_last   <= s3_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
